// ===== hw/rtl/dcb_pkg.sv =====
// Shared types and constants for the multichannel DC blocker.
// Used by dcb_regs and multichannel_dc_blocker; depends on nothing.
`default_nettype none
package dcb_pkg;

  localparam int DATA_W       = 32;
  localparam int CH_W         = 2;
  localparam int FMT_W        = 2;
  localparam int NUM_COEF     = 4;
  localparam int DEF_CHANNELS = 4;
  localparam int APB_AW       = 5;
  localparam int REG_IDX_W    = 3;

  // sample format codes
  localparam logic [FMT_W-1:0] FMT_S16 = 2'd0;
  localparam logic [FMT_W-1:0] FMT_S24 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_S32 = 2'd2;

  // register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_FORMAT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF0  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF1  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEF2  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COEF3  = 3'd4;

  typedef struct packed {
    logic [FMT_W-1:0]                  fmt;
    logic [NUM_COEF-1:0][DATA_W-1:0]   coef;
  } dcb_cfg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dcb_regs.sv =====
// APB register file for the DC blocker: sample format and per-channel coefficients.
// Depends on dcb_pkg.
`default_nettype none
module dcb_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [dcb_pkg::APB_AW-1:0]  paddr,
  input  wire logic [dcb_pkg::DATA_W-1:0]  pwdata,
  output logic      [dcb_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output dcb_pkg::dcb_cfg_t                cfg
);
  import dcb_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr;

  assign idx    = paddr[APB_AW-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fmt  <= FMT_S32;
      cfg.coef <= '0;
    end else if (wr) begin
      case (idx)
        REG_FORMAT: cfg.fmt     <= pwdata[FMT_W-1:0];
        REG_COEF0:  cfg.coef[0] <= pwdata;
        REG_COEF1:  cfg.coef[1] <= pwdata;
        REG_COEF2:  cfg.coef[2] <= pwdata;
        REG_COEF3:  cfg.coef[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FORMAT: prdata = {{(DATA_W-FMT_W){1'b0}}, cfg.fmt};
      REG_COEF0:  prdata = cfg.coef[0];
      REG_COEF1:  prdata = cfg.coef[1];
      REG_COEF2:  prdata = cfg.coef[2];
      REG_COEF3:  prdata = cfg.coef[3];
      default:    prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/multichannel_dc_blocker.sv =====
// Top level of the multichannel first-order DC blocker: history memory and
// three-stage datapath. Depends on dcb_pkg and dcb_regs.
//
//  Channel   Direction  Handshake              Payload
//  --------  ---------  ---------------------  --------------------------------
//  apb       in/out     psel/penable/pready    paddr, pwrite, pwdata, prdata
//  in        in         in_valid / in_ready    sample_in, channel, block_end
//  out       out        out_valid / out_ready  sample_out, channel_out, block_end_out
//
// One request per clock is accepted unless the output stalls or the interlock holds
// it; a request passes through the s1, s2 and output registers in turn. The
// per-channel recursion through the history memory keeps two requests on the same
// channel apart: the later one waits until the earlier one writes back its history
// (an interlock on the channel index, with a bypass register for the write that
// lands on the same edge as the read). Reset clears the entry valid bits at once;
// an entry never written reads as zero, so there is no clearing pass. A stalled
// output holds its result while up to two further requests queue in the pipeline.
`default_nettype none
module multichannel_dc_blocker #(
  parameter int CHANNELS = dcb_pkg::DEF_CHANNELS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [dcb_pkg::APB_AW-1:0]  paddr,
  input  wire logic [dcb_pkg::DATA_W-1:0]  pwdata,
  output logic      [dcb_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  // sample requests
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [dcb_pkg::DATA_W-1:0]  sample_in,
  input  wire logic [dcb_pkg::CH_W-1:0]    channel,
  input  wire logic                        block_end,
  // results
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [dcb_pkg::DATA_W-1:0]  sample_out,
  output logic      [dcb_pkg::CH_W-1:0]    channel_out,
  output logic                             block_end_out
);
  import dcb_pkg::*;

  localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = CH_W + 1;
  localparam int HW    = 2 * DATA_W;     // history entry: {x_prev, y_prev}
  localparam int PW    = 2 * DATA_W;     // product width
  localparam int SH_W  = PW - 29;        // product after the first shift
  localparam int ACC_W = SH_W + 2;

  dcb_cfg_t cfg;

  dcb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------------------
  // Stage 0: request intake, format alignment to Q1.31, history read
  // ---------------------------------------------------------------------------
  logic              in_fire;
  logic              ch_ok0;
  logic [AW-1:0]     idx0;
  logic [DATA_W-1:0] x0;
  logic              hazard;

  logic              s1_valid, s1_ok, s1_end;
  logic [CH_W-1:0]   s1_ch;
  logic [DATA_W-1:0] s1_x;
  logic              s2_valid, s2_ok, s2_end;
  logic [CH_W-1:0]   s2_ch;
  logic [DATA_W-1:0] s2_x;
  logic [DATA_W:0]   s2_diff;
  logic [PW-1:0]     s2_prod;
  logic              s1_ready, s2_ready, s2_fire;

  assign ch_ok0 = ({1'b0, channel} < CNT_W'(CHANNELS));
  assign idx0   = channel[AW-1:0];

  always_comb begin
    case (cfg.fmt)
      FMT_S16: x0 = {sample_in[15:0], 16'd0};
      FMT_S24: x0 = {sample_in[23:0], 8'd0};
      default: x0 = sample_in;
    endcase
  end

  // Hold a request whose channel still has an older request before write-back.
  assign hazard = ch_ok0 &&
                  ((s1_valid && (s1_ch == channel)) ||
                   (s2_valid && (s2_ch == channel) && !s2_fire));

  assign in_ready = s1_ready && !hazard;
  assign in_fire  = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // History memory: one entry per channel, one read and one write port
  // ---------------------------------------------------------------------------
  logic [HW-1:0]       hist_mem [CHANNELS];
  logic [CHANNELS-1:0] hist_vld;
  logic [HW-1:0]       rd_data;
  logic                rd_vld;
  logic                fwd_hit;
  logic [HW-1:0]       fwd_data;
  logic                rd_en;
  logic                wr_en;
  logic [AW-1:0]       wr_idx;
  logic [HW-1:0]       wr_data;

  assign rd_en = in_fire && ch_ok0;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= hist_mem[idx0];
    end
    if (wr_en) begin
      hist_mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_vld <= '0;
      rd_vld   <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (wr_en) begin
        hist_vld[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld  <= hist_vld[idx0];
        // write on the read edge: the array still returns the old entry
        fwd_hit <= wr_en && (wr_idx == idx0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data <= wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: feedback product R * y_prev and input difference
  // ---------------------------------------------------------------------------
  logic [HW-1:0]            hist1;
  logic [DATA_W-1:0]        xp1, yp1, coef1;
  logic signed [PW-1:0]     prod1;
  logic [DATA_W:0]          diff1;

  always_comb begin
    if (fwd_hit) begin
      hist1 = fwd_data;
    end else if (rd_vld) begin
      hist1 = rd_data;
    end else begin
      hist1 = '0;
    end
  end

  assign xp1   = hist1[HW-1:DATA_W];
  assign yp1   = hist1[DATA_W-1:0];
  assign coef1 = cfg.coef[s1_ch];
  assign prod1 = $signed(coef1) * $signed(yp1);
  assign diff1 = {s1_x[DATA_W-1], s1_x} - {xp1[DATA_W-1], xp1};

  assign s2_fire  = s2_valid && (!out_valid || out_ready);
  assign s2_ready = !s2_valid || s2_fire;
  assign s1_ready = !s1_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_fire;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ok  <= ch_ok0;
      s1_ch  <= channel;
      s1_end <= block_end;
      s1_x   <= x0;
    end
    if (s1_valid && s2_ready) begin
      s2_ok   <= s1_ok;
      s2_ch   <= s1_ch;
      s2_end  <= s1_end;
      s2_x    <= s1_x;
      s2_diff <= diff1;
      s2_prod <= prod1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: round product to Q1.31, sum, saturate, write back, format output
  // ---------------------------------------------------------------------------
  logic [SH_W-1:0]   prod_sh;
  logic [SH_W:0]     prod_inc;
  logic [SH_W-1:0]   prod_rnd;
  logic [ACC_W-1:0]  acc;
  logic [DATA_W-1:0] y2;
  logic [17:0]       r16_inc;
  logic [16:0]       r16;
  logic [15:0]       s16;
  logic [25:0]       r24_inc;
  logic [24:0]       r24;
  logic [23:0]       s24;
  logic [DATA_W-1:0] res2;

  assign prod_sh  = s2_prod[PW-1:29];
  assign prod_inc = {prod_sh[SH_W-1], prod_sh} + (SH_W+1)'(1);
  assign prod_rnd = prod_inc[SH_W:1];

  assign acc = {{(ACC_W-DATA_W-1){s2_diff[DATA_W]}}, s2_diff} +
               {{(ACC_W-SH_W){prod_rnd[SH_W-1]}}, prod_rnd};

  // saturate to 32 bits: all bits above the sign must match it
  always_comb begin
    if (acc[ACC_W-1:DATA_W-1] == '0 || acc[ACC_W-1:DATA_W-1] == '1) begin
      y2 = acc[DATA_W-1:0];
    end else if (acc[ACC_W-1]) begin
      y2 = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      y2 = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  // round back to 16 bits
  assign r16_inc = {y2[DATA_W-1], y2[DATA_W-1:15]} + 18'd1;
  assign r16     = r16_inc[17:1];
  always_comb begin
    if (r16[16] == r16[15]) begin
      s16 = r16[15:0];
    end else if (r16[16]) begin
      s16 = 16'h8000;
    end else begin
      s16 = 16'h7fff;
    end
  end

  // round back to 24 bits
  assign r24_inc = {y2[DATA_W-1], y2[DATA_W-1:7]} + 26'd1;
  assign r24     = r24_inc[25:1];
  always_comb begin
    if (r24[24] == r24[23]) begin
      s24 = r24[23:0];
    end else if (r24[24]) begin
      s24 = 24'h800000;
    end else begin
      s24 = 24'h7fffff;
    end
  end

  always_comb begin
    if (!s2_ok) begin
      res2 = '0;
    end else begin
      case (cfg.fmt)
        FMT_S16: res2 = {{(DATA_W-16){s16[15]}}, s16};
        FMT_S24: res2 = {{(DATA_W-24){s24[23]}}, s24};
        default: res2 = y2;
      endcase
    end
  end

  // write back history as the result leaves the stage
  assign wr_en   = s2_fire && s2_ok;
  assign wr_idx  = s2_ch[AW-1:0];
  assign wr_data = {s2_x, y2};

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      sample_out    <= res2;
      channel_out   <= s2_ch;
      block_end_out <= s2_end;
    end
  end

endmodule
`default_nettype wire

// ===== verif/tb_multichannel_dc_blocker.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for multichannel_dc_blocker: APB setup, request and result streams.
// Depends on dcb_pkg and the block's RTL; the expected outputs come from a predictor kept below.

module tb_multichannel_dc_blocker;
  import dcb_pkg::*;

  // format code 3 is not named in the package; the block treats it as s32
  localparam logic [FMT_W-1:0] FMT_ALIAS_S32 = 2'd3;
  localparam logic [FMT_W-1:0] FMT_ORDER [4] = '{FMT_S16, FMT_S24, FMT_S32, FMT_ALIAS_S32};
  localparam int unsigned      RAND_PHASES   = 8;
  localparam int unsigned      CYCLE_LIMIT   = 400_000;
  localparam int unsigned      SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [DATA_W-1:0] sample;
    logic [CH_W-1:0]   chan;
    logic              blk_end;
  } filt_result_t;

  // Predictor of the filter plus the queue of results still owed by the block.
  class dc_filter_check;
    logic [FMT_W-1:0]  fmt_reg;
    logic [DATA_W-1:0] coef_reg [NUM_COEF];
    logic [DATA_W-1:0] last_in  [DEF_CHANNELS];
    logic [DATA_W-1:0] last_out [DEF_CHANNELS];
    filt_result_t      expected_outputs[$];
    int unsigned       errors;

    function new();
      fmt_reg = FMT_S32;
      errors  = 0;
      foreach (coef_reg[i]) coef_reg[i] = '0;
      foreach (last_in[i]) begin
        last_in[i]  = '0;
        last_out[i] = '0;
      end
    endfunction

    function longint widen(logic [DATA_W-1:0] v);
      return {{32{v[DATA_W-1]}}, v};
    endfunction

    // add half an LSB at the new scale, then drop s bits
    function longint round_shift(longint v, int unsigned s);
      return ((v >>> (s - 1)) + 1) >>> 1;
    endfunction

    function longint clamp(longint v, int unsigned bits);
      longint hi;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function void set_register(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_FORMAT: fmt_reg = value[FMT_W-1:0];
        REG_COEF0, REG_COEF1, REG_COEF2, REG_COEF3: coef_reg[idx - REG_COEF0] = value;
        default: ;
      endcase
    endfunction

    function void note_request(logic [DATA_W-1:0] smp, logic [CH_W-1:0] ch, logic be);
      filt_result_t res;
      longint       x, y;
      res.chan    = ch;
      res.blk_end = be;
      res.sample  = '0;
      if (int'(ch) < DEF_CHANNELS) begin
        // lift the input to Q1.31; bits above the format width are dropped
        case (fmt_reg)
          FMT_S16: x = {{32{smp[15]}}, smp[15:0], 16'h0000};
          FMT_S24: x = {{32{smp[23]}}, smp[23:0], 8'h00};
          default: x = widen(smp);
        endcase
        y = clamp(x - widen(last_in[ch])
                  + round_shift(widen(coef_reg[ch]) * widen(last_out[ch]), 30), 32);
        last_in[ch]  = 32'(x);
        last_out[ch] = 32'(y);
        case (fmt_reg)
          FMT_S16: res.sample = 32'(clamp(round_shift(y, 16), 16));
          FMT_S24: res.sample = 32'(clamp(round_shift(y, 8), 24));
          default: res.sample = 32'(y);
        endcase
      end
      expected_outputs.push_back(res);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%0t mismatch: %s", $time, msg);
    endfunction

    function void check_result(logic [DATA_W-1:0] smp, logic [CH_W-1:0] ch, logic be);
      filt_result_t want;
      if (expected_outputs.size() == 0) begin
        flag($sformatf("result with nothing pending: sample %h ch %0d end %b", smp, ch, be));
        return;
      end
      want = expected_outputs.pop_front();
      if (smp !== want.sample || ch !== want.chan || be !== want.blk_end)
        flag($sformatf("expected sample %h ch %0d end %b, got sample %h ch %0d end %b",
                       want.sample, want.chan, want.blk_end, smp, ch, be));
    endfunction

    function int unsigned pending();
      return expected_outputs.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                psel, penable, pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata, prdata;
  logic                pready;
  logic                in_valid, in_ready;
  logic [DATA_W-1:0]   sample_in;
  logic [CH_W-1:0]     channel;
  logic                block_end;
  logic                out_valid, out_ready;
  logic [DATA_W-1:0]   sample_out;
  logic [CH_W-1:0]     channel_out;
  logic                block_end_out;

  dc_filter_check      sb;
  bit                  sender_idle;
  bit                  sink_idle;
  logic [CH_W-1:0]     last_ch;
  logic [DATA_W-1:0]   dc_level [DEF_CHANNELS];
  int unsigned         cycle_count;

  multichannel_dc_blocker u_top (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample_in     (sample_in),
    .channel       (channel),
    .block_end     (block_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sample_out    (sample_out),
    .channel_out   (channel_out),
    .block_end_out (block_end_out)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Run against the cycle budget; reaching it means something hung.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[multichannel_dc_blocker] ERROR");
    $finish;
  end

  // Check every result the moment it is taken. Values read here are the ones
  // from before the edge, so the block's own updates cannot race the check.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(sample_out, channel_out, block_end_out);
  end

  // Result side: ready in random runs broken by random stalls,
  // or always ready when the phase turns idling off.
  initial begin : result_sink
    int unsigned run_len;
    int unsigned stall_len;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_idle) begin
        run_len   = $urandom_range(1, 40);
        stall_len = $urandom_range(1, 13);
        out_ready <= 1'b1;
        repeat (run_len) @(posedge clk);
        out_ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Present one request and hold it until taken. Valid stays high on return so
  // the next request can follow in the very next cycle.
  task automatic send_sample(input logic [DATA_W-1:0] smp, input logic [CH_W-1:0] ch,
                             input logic be);
    in_valid  <= 1'b1;
    sample_in <= smp;
    channel   <= ch;
    block_end <= be;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(smp, ch, be);
  endtask

  // Drop valid for a burst of idle cycles.
  task automatic hold_off(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop sending and wait until every owed result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Setup cycle, access cycle, then psel drops and the task waits for a clock edge, so that
  // back-to-back writes never put two assignments on psel in one step.
  task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk);
  endtask

  task automatic program_filter(input logic [DATA_W-1:0] fmt_word, input logic [DATA_W-1:0] c0,
                                input logic [DATA_W-1:0] c1, input logic [DATA_W-1:0] c2,
                                input logic [DATA_W-1:0] c3);
    write_register(REG_FORMAT, fmt_word);
    write_register(REG_COEF0, c0);
    write_register(REG_COEF1, c1);
    write_register(REG_COEF2, c2);
    write_register(REG_COEF3, c3);
  endtask

  // Half the time a leaky integrator pole just under 1.0, as a real DC blocker uses,
  // with the odd extreme or fully random coefficient.
  function automatic logic [DATA_W-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return 32'h4000_0000 - $urandom_range(0, 32'h0040_0000);
      4:          return $urandom;
      5:          return 32'h7FFF_FFFF;
      6:          return 32'h8000_0000;
      default:    return 32'hC000_0000;
    endcase
  endfunction

  // Build a full-scale sample, then scale it to the format. Most samples ride
  // on the channel's DC level so the recursion has something to remove.
  function automatic logic [DATA_W-1:0] pick_sample(input logic [FMT_W-1:0] fmt,
                                                    input logic [CH_W-1:0] ch);
    logic [DATA_W-1:0] full;
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 15))
      0:          full = 32'h7FFF_FFFF;
      1:          full = 32'h8000_0000;
      2:          full = '0;
      3, 4, 5, 6: full = $urandom;
      default:    full = dc_level[ch] + $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    endcase
    case (fmt)
      FMT_S16: v = 32'($signed(full) >>> 16);
      FMT_S24: v = 32'($signed(full) >>> 8);
      default: v = full;
    endcase
    // scribble over the container bits the format ignores now and then
    if (fmt == FMT_S16 && $urandom_range(0, 5) == 0) v[31:16] = 16'($urandom);
    if (fmt == FMT_S24 && $urandom_range(0, 5) == 0) v[31:24] = 8'($urandom);
    return v;
  endfunction

  // Random request; a third of the time reuse the last channel to hit the
  // same-channel interlock back to back.
  task automatic send_random(input logic [FMT_W-1:0] fmt);
    logic [CH_W-1:0] ch;
    if (sender_idle && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 13));
    ch      = ($urandom_range(0, 2) == 0) ? last_ch : CH_W'($urandom);
    last_ch = ch;
    send_sample(pick_sample(fmt, ch), ch, $urandom_range(0, 15) == 0);
  endtask

  initial begin : stimulus
    logic [FMT_W-1:0] phase_fmt;
    int unsigned      n_items;
    sb          = new();
    sender_idle = 1'b0;
    sink_idle   = 1'b0;
    last_ch     = '0;
    rst       <= 1'b1;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    in_valid  <= 1'b0;
    sample_in <= '0;
    channel   <= '0;
    block_end <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings (s32, zero feedback): full-scale swings saturate both ways.
    send_sample(32'h7FFF_FFFF, 2'd0, 1'b0);
    send_sample(32'h8000_0000, 2'd0, 1'b0);
    send_sample(32'h8000_0000, 2'd1, 1'b0);
    send_sample(32'h7FFF_FFFF, 2'd1, 1'b0);
    send_sample(32'h0000_0000, 2'd2, 1'b0);
    send_sample(32'hFFFF_FFFF, 2'd3, 1'b1);

    // Extreme poles: largest and most negative coefficient, exactly one, just below one.
    drain_results();
    program_filter({30'd0, FMT_S32}, 32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000, 32'h3FF0_0000);
    send_sample(32'h7FFF_FFFF, 2'd0, 1'b0);
    send_sample(32'h7FFF_FFFF, 2'd0, 1'b0);
    send_sample(32'h7FFF_FFFF, 2'd1, 1'b0);
    send_sample(32'h8000_0000, 2'd1, 1'b0);
    send_sample(32'h0001_E240, 2'd2, 1'b0);
    send_sample(32'h8000_0000, 2'd3, 1'b1);

    // s16, format word carrying junk in its upper bits; samples with junk above bit 15
    drain_results();
    write_register(REG_FORMAT, {30'h2AAA_AAAA, FMT_S16});
    send_sample(32'h0000_7FFF, 2'd0, 1'b0);
    send_sample(32'hABCD_8000, 2'd1, 1'b0);
    send_sample(32'hFFFF_0001, 2'd2, 1'b0);
    send_sample(32'h1234_0000, 2'd3, 1'b1);

    // s24 extremes and junk above bit 23
    drain_results();
    write_register(REG_FORMAT, {30'd0, FMT_S24});
    send_sample(32'h007F_FFFF, 2'd0, 1'b0);
    send_sample(32'hFF80_0000, 2'd1, 1'b0);
    send_sample(32'h5A00_0001, 2'd2, 1'b0);
    send_sample(32'h0000_0000, 2'd3, 1'b1);

    // unnamed format code behaves as s32
    drain_results();
    write_register(REG_FORMAT, {30'd0, FMT_ALIAS_S32});
    send_sample(32'h8000_0000, 2'd0, 1'b0);
    send_sample(32'h7FFF_FFFF, 2'd1, 1'b0);
    send_sample(32'hDEAD_BEEF, 2'd2, 1'b1);

    // Random phases: new format, poles and DC levels each time. Phase 2 and the
    // last phase run without idling on either side.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_results();
      sender_idle = (ph != 2) && (ph != RAND_PHASES - 1);
      sink_idle   = sender_idle;
      phase_fmt   = (ph < 4) ? FMT_ORDER[ph] : FMT_ORDER[$urandom_range(0, 3)];
      for (int c = 0; c < DEF_CHANNELS; c++)
        dc_level[c] = ($urandom_range(0, 1) == 0) ? $urandom : 32'($signed($urandom) >>> 6);
      program_filter({30'd0, phase_fmt}, pick_coef(), pick_coef(), pick_coef(), pick_coef());
      n_items = $urandom_range(110, 165);
      for (int k = 0; k < n_items; k++) begin
        // halfway through one phase, hold requests until the pipe is empty
        if (ph == 3 && k == n_items / 2) drain_results();
        send_random(phase_fmt);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[multichannel_dc_blocker] OK");
    end else begin
      $display("[multichannel_dc_blocker] ERROR");
    end
    $finish;
  end

endmodule
